// ----- rtl/jacm_pkg.sv -----
// ============================================================================
// jacm_pkg: shared definitions for the joystick axis calibration block
// Register indexes, reset values, fixed widths and pipeline depth.
// ============================================================================
package jacm_pkg;

    // Default raw sample width and fixed output value width.
    localparam int SAMPLE_BITS_DEF = 12;
    localparam int OUT_BITS        = 12;

    // The scaled offset never exceeds the output span, so the quotient
    // needs one restoring step for each output bit.
    localparam int DIV_STEPS = OUT_BITS;

    // Clamp, offset, selection, product plus divider steps, output register.
    localparam int PIPE_DEPTH = 3 + (DIV_STEPS + 1) + 1;

    // Configuration register indexes.
    typedef enum logic [2:0] {
        REG_IN_LOW    = 3'd0,
        REG_IN_MID    = 3'd1,
        REG_IN_HIGH   = 3'd2,
        REG_DEAD_BAND = 3'd3,
        REG_FLIP_AXIS = 3'd4,
        REG_OUT_LOW   = 3'd5,
        REG_OUT_MID   = 3'd6,
        REG_OUT_HIGH  = 3'd7
    } cfg_reg_t;

    // Reset values of the configuration registers.
    localparam int RST_IN_LOW    = 1435;
    localparam int RST_IN_MID    = 1835;
    localparam int RST_IN_HIGH   = 2235;
    localparam int RST_DEAD_BAND = 100;
    localparam int RST_FLIP_AXIS = 1;
    localparam int RST_OUT_LOW   = 'hFA;
    localparam int RST_OUT_MID   = 'h740;
    localparam int RST_OUT_HIGH  = 'hF47;

endpackage

// ----- rtl/joystick_axis_calibrate_map.sv -----
// ============================================================================
// joystick_axis_calibrate_map
// Dead band and piecewise-linear calibration of one joystick axis sample.
// ============================================================================
//
//  Channel   Direction  Handshake           Payload
//  --------  ---------  ------------------  ---------------------------
//  input     in         in_valid/in_stall   raw_sample
//  output    out        out_valid/out_stall axis_value, in_dead_band
//  config    in         cfg_write           cfg_index, cfg_data
//
// One sample is accepted per cycle while in_stall is low; each result passes
// through every stage in order and is held until taken with out_stall low.
// The restoring divider has twelve register stages, one quotient bit each,
// behind the clamp, offset, selection and product stages of the pipeline.
// Every stage holds its own valid bit and advances whenever the stage after
// it is empty or moving, so bubbles close up while the output is stalled.
// Reset clears all valid bits and loads the default calibration.
// ============================================================================
module joystick_axis_calibrate_map
    import jacm_pkg::*;
#(
    parameter int SAMPLE_BITS = SAMPLE_BITS_DEF,
    localparam int CFG_BITS = (SAMPLE_BITS > OUT_BITS) ? SAMPLE_BITS : OUT_BITS
)
(
    input  logic                   clk,
    input  logic                   rst_n,

    input  logic                   cfg_write,
    input  logic [2:0]             cfg_index,
    input  logic [CFG_BITS-1:0]    cfg_data,

    input  logic                   in_valid,
    output logic                   in_stall,
    input  logic [SAMPLE_BITS-1:0] raw_sample,

    output logic                   out_valid,
    input  logic                   out_stall,
    output logic [OUT_BITS-1:0]    axis_value,
    output logic                   in_dead_band
);

    localparam int SB = SAMPLE_BITS;
    localparam int PW = SAMPLE_BITS + OUT_BITS;
    localparam int NDV = DIV_STEPS + 1;

    // ------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------
    logic [SB-1:0]       in_low_reg;
    logic [SB-1:0]       in_mid_reg;
    logic [SB-1:0]       in_high_reg;
    logic [SB-1:0]       dead_band_reg;
    logic                flip_axis_reg;
    logic [OUT_BITS-1:0] out_low_reg;
    logic [OUT_BITS-1:0] out_mid_reg;
    logic [OUT_BITS-1:0] out_high_reg;

    // Register writes; bits above a register's width are dropped.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_low_reg    <= SB'(RST_IN_LOW);
            in_mid_reg    <= SB'(RST_IN_MID);
            in_high_reg   <= SB'(RST_IN_HIGH);
            dead_band_reg <= SB'(RST_DEAD_BAND);
            flip_axis_reg <= 1'(RST_FLIP_AXIS);
            out_low_reg   <= OUT_BITS'(RST_OUT_LOW);
            out_mid_reg   <= OUT_BITS'(RST_OUT_MID);
            out_high_reg  <= OUT_BITS'(RST_OUT_HIGH);
        end
        else if (cfg_write)
        begin
            unique case (cfg_reg_t'(cfg_index))
                REG_IN_LOW:    in_low_reg    <= cfg_data[SB-1:0];
                REG_IN_MID:    in_mid_reg    <= cfg_data[SB-1:0];
                REG_IN_HIGH:   in_high_reg   <= cfg_data[SB-1:0];
                REG_DEAD_BAND: dead_band_reg <= cfg_data[SB-1:0];
                REG_FLIP_AXIS: flip_axis_reg <= cfg_data[0];
                REG_OUT_LOW:   out_low_reg   <= cfg_data[OUT_BITS-1:0];
                REG_OUT_MID:   out_mid_reg   <= cfg_data[OUT_BITS-1:0];
                REG_OUT_HIGH:  out_high_reg  <= cfg_data[OUT_BITS-1:0];
                default:       ;
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Pipeline registers
    // ------------------------------------------------------------------
    // Stage A: clamped sample.
    logic          a_vld_reg;
    logic [SB-1:0] a_samp_reg;
    logic [SB-1:0] a_samp_next;

    // Stage B: offset magnitude, direction and signed half range.
    logic          b_vld_reg;
    logic          b_pos_reg;
    logic [SB-1:0] b_mag_reg;
    logic [SB:0]   b_den_reg;
    logic          b_pos_next;
    logic [SB-1:0] b_mag_next;
    logic [SB:0]   b_den_next;

    // Stage C: dead band flag, ratio terms and output span.
    logic                c_vld_reg;
    logic                c_dead_reg;
    logic [SB-1:0]       c_num_reg;
    logic [SB-1:0]       c_den_reg;
    logic                c_neg_reg;
    logic [OUT_BITS-1:0] c_span_reg;
    logic                c_dead_next;
    logic [SB-1:0]       c_num_next;
    logic [SB-1:0]       c_den_next;
    logic                c_neg_next;
    logic [OUT_BITS-1:0] c_span_next;
    logic                c_up;
    logic                c_bad;

    // Divider stages: entry 0 holds the product, entry k the k-th step.
    logic                dv_vld_reg  [NDV];
    logic                dv_dead_reg [NDV];
    logic                dv_neg_reg  [NDV];
    logic [SB-1:0]       dv_den_reg  [NDV];
    logic [SB-1:0]       dv_rem_reg  [NDV];
    logic [OUT_BITS-1:0] dv_low_reg  [NDV];
    logic [OUT_BITS-1:0] dv_q_reg    [NDV];
    logic [SB-1:0]       dv_rem_next [NDV];
    logic [OUT_BITS-1:0] dv_low_next [NDV];
    logic [OUT_BITS-1:0] dv_q_next   [NDV];
    logic [PW-1:0]       dv_prod;

    // Output register.
    logic                out_vld_reg;
    logic [OUT_BITS-1:0] out_value_reg;
    logic                out_dead_reg;
    logic [OUT_BITS-1:0] out_value_next;

    // Stage ready flags.
    logic rdy_a;
    logic rdy_b;
    logic rdy_c;
    logic rdy_out;
    logic dv_rdy [NDV];

    // ------------------------------------------------------------------
    // Flow control: a stage may load when it is empty or its item moves on.
    // ------------------------------------------------------------------
    always_comb
    begin
        rdy_out = !out_vld_reg || !out_stall;
        for (int k = NDV - 1; k >= 0; k--)
        begin
            if (k == NDV - 1)
            begin
                dv_rdy[k] = !dv_vld_reg[k] || rdy_out;
            end
            else
            begin
                dv_rdy[k] = !dv_vld_reg[k] || dv_rdy[k + 1];
            end
        end
        rdy_c = !c_vld_reg || dv_rdy[0];
        rdy_b = !b_vld_reg || rdy_c;
        rdy_a = !a_vld_reg || rdy_b;
    end

    assign in_stall = !rdy_a;

    // ------------------------------------------------------------------
    // Stage A logic: raise to the minimum, then lower to the maximum.
    // ------------------------------------------------------------------
    always_comb
    begin
        a_samp_next = (raw_sample < in_low_reg) ? in_low_reg : raw_sample;
        if (a_samp_next > in_high_reg)
        begin
            a_samp_next = in_high_reg;
        end
    end

    // ------------------------------------------------------------------
    // Stage B logic: offset from center and the half range on that side.
    // ------------------------------------------------------------------
    always_comb
    begin
        b_pos_next = a_samp_reg > in_mid_reg;
        if (b_pos_next)
        begin
            b_mag_next = a_samp_reg - in_mid_reg;
            b_den_next = {1'b0, in_high_reg} - {1'b0, in_mid_reg};
        end
        else
        begin
            b_mag_next = in_mid_reg - a_samp_reg;
            b_den_next = {1'b0, in_mid_reg} - {1'b0, in_low_reg};
        end
    end

    // ------------------------------------------------------------------
    // Stage C logic: dead band test, full deflection fallback, span choice.
    // ------------------------------------------------------------------
    always_comb
    begin
        c_dead_next = b_mag_reg <= dead_band_reg;
        c_bad       = b_den_reg[SB] || (b_den_reg == '0) || ({1'b0, b_mag_reg} > b_den_reg);
        c_num_next  = c_bad ? SB'(1) : b_mag_reg;
        c_den_next  = c_bad ? SB'(1) : b_den_reg[SB-1:0];
        c_up        = b_pos_reg != flip_axis_reg;
        if (c_up)
        begin
            c_neg_next  = out_high_reg < out_mid_reg;
            c_span_next = c_neg_next ? (out_mid_reg - out_high_reg)
                                     : (out_high_reg - out_mid_reg);
        end
        else
        begin
            c_neg_next  = out_low_reg < out_mid_reg;
            c_span_next = c_neg_next ? (out_mid_reg - out_low_reg)
                                     : (out_low_reg - out_mid_reg);
        end
    end

    // ------------------------------------------------------------------
    // Product and restoring division steps, one quotient bit per stage.
    // The product is below den * 2^OUT_BITS, so its upper part starts as
    // a valid remainder.
    // ------------------------------------------------------------------
    assign dv_prod = PW'(c_num_reg) * PW'(c_span_reg);

    always_comb
    begin
        logic [SB:0] trial;
        logic        take;
        dv_rem_next[0] = dv_prod[PW-1:OUT_BITS];
        dv_low_next[0] = dv_prod[OUT_BITS-1:0];
        dv_q_next[0]   = '0;
        for (int k = 1; k < NDV; k++)
        begin
            trial          = {dv_rem_reg[k-1], dv_low_reg[k-1][OUT_BITS-1]};
            take           = trial >= {1'b0, dv_den_reg[k-1]};
            dv_rem_next[k] = take ? SB'(trial - {1'b0, dv_den_reg[k-1]}) : SB'(trial);
            dv_low_next[k] = {dv_low_reg[k-1][OUT_BITS-2:0], 1'b0};
            dv_q_next[k]   = {dv_q_reg[k-1][OUT_BITS-2:0], take};
        end
    end

    // ------------------------------------------------------------------
    // Output logic: floor upward, ceiling downward, then clamp; dead band gives the middle value.
    // ------------------------------------------------------------------
    always_comb
    begin
        logic [OUT_BITS:0]          step;
        logic signed [OUT_BITS+1:0] res;
        logic signed [OUT_BITS+1:0] lim_lo;
        logic signed [OUT_BITS+1:0] lim_hi;
        step   = {1'b0, dv_q_reg[NDV-1]}
               + (OUT_BITS + 1)'(dv_neg_reg[NDV-1] && (dv_rem_reg[NDV-1] != '0));
        lim_lo = $signed({2'b00, out_low_reg});
        lim_hi = $signed({2'b00, out_high_reg});
        if (dv_neg_reg[NDV-1])
        begin
            res = $signed({2'b00, out_mid_reg}) - $signed({1'b0, step});
        end
        else
        begin
            res = $signed({2'b00, out_mid_reg}) + $signed({1'b0, step});
        end
        if (res < lim_lo)
        begin
            res = lim_lo;
        end
        else if (res > lim_hi)
        begin
            res = lim_hi;
        end
        out_value_next = dv_dead_reg[NDV-1] ? out_mid_reg : res[OUT_BITS-1:0];
    end

    // ------------------------------------------------------------------
    // Valid bits.
    // ------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_vld_reg   <= 1'b0;
            b_vld_reg   <= 1'b0;
            c_vld_reg   <= 1'b0;
            out_vld_reg <= 1'b0;
            for (int k = 0; k < NDV; k++)
            begin
                dv_vld_reg[k] <= 1'b0;
            end
        end
        else
        begin
            if (rdy_a)
            begin
                a_vld_reg <= in_valid;
            end
            if (rdy_b)
            begin
                b_vld_reg <= a_vld_reg;
            end
            if (rdy_c)
            begin
                c_vld_reg <= b_vld_reg;
            end
            if (dv_rdy[0])
            begin
                dv_vld_reg[0] <= c_vld_reg;
            end
            for (int k = 1; k < NDV; k++)
            begin
                if (dv_rdy[k])
                begin
                    dv_vld_reg[k] <= dv_vld_reg[k-1];
                end
            end
            if (rdy_out)
            begin
                out_vld_reg <= dv_vld_reg[NDV-1];
            end
        end
    end

    // ------------------------------------------------------------------
    // Payload registers, loaded when the stage takes a transaction.
    // ------------------------------------------------------------------
    always_ff @(posedge clk)
    begin
        if (rdy_a && in_valid)
        begin
            a_samp_reg <= a_samp_next;
        end
        if (rdy_b && a_vld_reg)
        begin
            b_pos_reg <= b_pos_next;
            b_mag_reg <= b_mag_next;
            b_den_reg <= b_den_next;
        end
        if (rdy_c && b_vld_reg)
        begin
            c_dead_reg <= c_dead_next;
            c_num_reg  <= c_num_next;
            c_den_reg  <= c_den_next;
            c_neg_reg  <= c_neg_next;
            c_span_reg <= c_span_next;
        end
        if (dv_rdy[0] && c_vld_reg)
        begin
            dv_dead_reg[0] <= c_dead_reg;
            dv_neg_reg[0]  <= c_neg_reg;
            dv_den_reg[0]  <= c_den_reg;
            dv_rem_reg[0]  <= dv_rem_next[0];
            dv_low_reg[0]  <= dv_low_next[0];
            dv_q_reg[0]    <= dv_q_next[0];
        end
        for (int k = 1; k < NDV; k++)
        begin
            if (dv_rdy[k] && dv_vld_reg[k-1])
            begin
                dv_dead_reg[k] <= dv_dead_reg[k-1];
                dv_neg_reg[k]  <= dv_neg_reg[k-1];
                dv_den_reg[k]  <= dv_den_reg[k-1];
                dv_rem_reg[k]  <= dv_rem_next[k];
                dv_low_reg[k]  <= dv_low_next[k];
                dv_q_reg[k]    <= dv_q_next[k];
            end
        end
        if (rdy_out && dv_vld_reg[NDV-1])
        begin
            out_value_reg <= out_value_next;
            out_dead_reg  <= dv_dead_reg[NDV-1];
        end
    end

    assign out_valid    = out_vld_reg;
    assign axis_value   = out_value_reg;
    assign in_dead_band = out_dead_reg;

endmodule

// ----- rtl/jacm_checker.sv -----
// ============================================================================
// jacm_checker: port-level checks for the joystick axis calibration block
// Tracks items in flight and checks flow control against the output side.
// ============================================================================
module jacm_checker
    import jacm_pkg::*;
#(
    parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
)
(
    input logic                   clk,
    input logic                   rst_n,
    input logic                   in_valid,
    input logic                   in_stall,
    input logic [SAMPLE_BITS-1:0] raw_sample,
    input logic                   out_valid,
    input logic                   out_stall,
    input logic [OUT_BITS-1:0]    axis_value,
    input logic                   in_dead_band
);

    localparam int CW = $clog2(PIPE_DEPTH + 1) + 1;

    logic          in_take;
    logic          out_take;
    logic [CW-1:0] occ_reg;
    logic [CW-1:0] occ_next;

    assign in_take  = in_valid && !in_stall;
    assign out_take = out_valid && !out_stall;

    // Count of transactions accepted but not yet delivered.
    always_comb
    begin
        occ_next = occ_reg + CW'(in_take) - CW'(out_take);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            occ_reg <= '0;
        end
        else
        begin
            occ_reg <= occ_next;
        end
    end

    // A stalled result holds its value.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(axis_value) && $stable(in_dead_band))
    else $error("stalled result changed");

    // A stalled input transaction keeps its sample.
    assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_stall |=> in_valid && $stable(raw_sample))
    else $error("stalled sample changed");

    // With an empty output register the whole pipeline can move.
    assert property (@(posedge clk) disable iff (!rst_n)
        !out_valid |-> !in_stall)
    else $error("input stalled while output is empty");

    // No result appears without an accepted sample behind it.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> occ_reg != '0)
    else $error("result without pending sample");

    // Items in flight never exceed the pipeline depth.
    assert property (@(posedge clk) disable iff (!rst_n)
        occ_reg <= CW'(PIPE_DEPTH))
    else $error("more items in flight than pipeline stages");

endmodule

bind joystick_axis_calibrate_map jacm_checker #(
    .SAMPLE_BITS (SAMPLE_BITS)
) u_jacm_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .raw_sample   (raw_sample),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .axis_value   (axis_value),
    .in_dead_band (in_dead_band)
);
